// ===== rtl/lmrs_pkg.sv =====
// Shared constants, codes and types of the LED matrix row scan refresh block.
package lmrs_pkg;

    localparam int ROW_COUNT     = 7;
    localparam int BYTES_PER_ROW = 8;
    localparam int STORE_SIZE    = ROW_COUNT * BYTES_PER_ROW;
    localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int ROW_W         = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int K_W           = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

    localparam int ALU_W      = 17;
    localparam int PERIOD_W   = 16;
    localparam int HIDDEN_W   = 3;
    localparam int POS_W      = 8;
    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PERIOD_W-1:0] ROW_PERIOD_RESET = 16'd1000;

    typedef enum logic [1:0] {
        MODE_TICK,
        MODE_WRITE,
        MODE_READ,
        MODE_FILL
    } t_mode;

    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_READ,
        KIND_SHIFT
    } t_kind;

    typedef enum logic {
        REG_ROW_PERIOD,
        REG_HIDDEN_COLUMNS
    } t_reg_idx;

    typedef enum logic {
        ALU_ADD,
        ALU_GT
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_ADD,
        ST_TICK_CMP,
        ST_ROW_ADD,
        ST_ROW_WRAP,
        ST_SCAN_RD,
        ST_SCAN_OUT,
        ST_PIX_POS,
        ST_PIX_CHK,
        ST_PIX_ADDR,
        ST_PIX_RD,
        ST_PIX_RESULT,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] row_period;
        logic [HIDDEN_W-1:0] hidden_columns;
    } t_cfg;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             gt;
    } t_alu_rsp;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              fill_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        logic [7:0]        fill_byte;
    } t_mem_req;

endpackage

// ===== rtl/lmrs_if.sv =====
// Valid/ready channel interfaces for the command items and the result items.
interface lmrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] column;
    logic [3:0] row;
    logic       pixel_value;
    logic [7:0] fill_byte;

    modport source (output valid, output mode, output column, output row,
                    output pixel_value, output fill_byte, input ready);
    modport sink (input valid, input mode, input column, input row,
                  input pixel_value, input fill_byte, output ready);
endinterface

interface lmrs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       pixel_out;
    logic [7:0] shift_byte;
    logic [3:0] active_row;
    logic       last;
    logic       error;

    modport source (output valid, output kind, output pixel_out, output shift_byte,
                    output active_row, output last, output error, input ready);
    modport sink (input valid, input kind, input pixel_out, input shift_byte,
                  input active_row, input last, input error, output ready);
endinterface

// ===== rtl/led_matrix_row_scan_refresh_top.sv =====
// Top level of the LED matrix row scan refresh block: register port and unit wiring.
//
// This block drives a row-multiplexed LED matrix from a one-bit-per-pixel frame store of
// ROW_COUNT rows by BYTES_PER_ROW bytes, cleared to dark at reset. Each command transaction
// ticks the row timer, writes or reads one pixel, or fills every store byte. A pixel sits at
// column plus hidden_columns: byte index is that sum divided by 8 and the bit is 7 minus the
// sum modulo 8, so the leftmost pixel is the most significant bit. A pixel outside the store
// returns error set and changes nothing. When a tick makes the elapsed count exceed
// row_period, the count clears, the scan row advances with wrap, and the new row's bytes go
// out one result transaction each, inverted (0 means lit), with last set on the final byte,
// the point where the row is switched on. A tick that does not advance yields no result; a
// pixel write or read or a fill yields exactly one result with last set. Commands are handled
// one at a time by a small sequencer around a single shared adder/comparator and a single-port
// frame store with registered read data, and the command channel is not ready until the
// current command has finished. A pixel outside the store skips the address step and the
// store read. Every row byte of an advancing tick needs a store read followed by an output
// step in which the adder forms the next address; a result not taken downstream stalls the
// sequencer. Fills take effect at once through per-byte valid bits and a common fill value,
// so there is no clearing pass after reset. Registers are row_period at byte address 0
// (reset 1000) and hidden_columns at byte address 4 (reset 0); write them only while the
// block is idle.
module led_matrix_row_scan_refresh_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lmrs_in_if.sink                            i_in,
    lmrs_out_if.source                         o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lmrs_pkg::PADDR_W-1:0]       paddr,
    input  logic [lmrs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lmrs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [lmrs_pkg::PERIOD_W-1:0] r_row_period;
    logic [lmrs_pkg::HIDDEN_W-1:0] r_hidden;
    logic                          apb_wr;
    lmrs_pkg::t_reg_idx            reg_idx;

    lmrs_pkg::t_cfg     cfg;
    lmrs_pkg::t_alu_req alu_req;
    lmrs_pkg::t_alu_rsp alu_rsp;
    lmrs_pkg::t_mem_req mem_req;
    logic [7:0]         rdata;

    // Registers are word spaced, so the word address bit selects the register.
    assign reg_idx = lmrs_pkg::t_reg_idx'(paddr[lmrs_pkg::PADDR_W-1]);
    assign apb_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_period <= lmrs_pkg::ROW_PERIOD_RESET;
            r_hidden     <= '0;
        end else if (apb_wr) begin
            unique case (reg_idx)
                lmrs_pkg::REG_ROW_PERIOD:     r_row_period <= pwdata[lmrs_pkg::PERIOD_W-1:0];
                lmrs_pkg::REG_HIDDEN_COLUMNS: r_hidden     <= pwdata[lmrs_pkg::HIDDEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lmrs_pkg::REG_ROW_PERIOD:     prdata = lmrs_pkg::APB_DATA_W'(r_row_period);
            lmrs_pkg::REG_HIDDEN_COLUMNS: prdata = lmrs_pkg::APB_DATA_W'(r_hidden);
        endcase
    end

    assign cfg.row_period     = r_row_period;
    assign cfg.hidden_columns = r_hidden;

    // The sequencer owns the command and result channels, the scan state and the timer.
    lmrs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_res     (o_res),
        .i_cfg     (cfg),
        .o_alu_req (alu_req),
        .i_alu_rsp (alu_rsp),
        .o_mem_req (mem_req),
        .i_rdata   (rdata)
    );

    // One adder handles the tick count, row wrap, pixel position, bounds and addresses.
    lmrs_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    lmrs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

// ===== rtl/lmrs_alu.sv =====
// Shared adder that serves both additions and greater-than compares.
module lmrs_alu (
    input  lmrs_pkg::t_alu_req i_req,
    output lmrs_pkg::t_alu_rsp o_rsp
);

    logic [lmrs_pkg::ALU_W-1:0] x;
    logic [lmrs_pkg::ALU_W-1:0] y;
    logic                       cin;
    logic [lmrs_pkg::ALU_W:0]   full;

    // A compare computes b - a; a missing carry out means a > b.
    always_comb begin
        x   = i_req.a;
        y   = i_req.b;
        cin = 1'b0;
        if (i_req.op == lmrs_pkg::ALU_GT) begin
            x   = i_req.b;
            y   = ~i_req.a;
            cin = 1'b1;
        end
        full      = {1'b0, x} + {1'b0, y} + (lmrs_pkg::ALU_W + 1)'(cin);
        o_rsp.sum = full[lmrs_pkg::ALU_W-1:0];
        o_rsp.gt  = (i_req.op == lmrs_pkg::ALU_GT) && !full[lmrs_pkg::ALU_W];
    end

endmodule

// ===== rtl/lmrs_store.sv =====
// Frame store memory with per-entry valid bits and a common fill value.
module lmrs_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lmrs_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0]                    r_mem [lmrs_pkg::STORE_SIZE];
    logic [lmrs_pkg::STORE_SIZE-1:0] r_valid;
    logic [7:0]                    r_fill;
    logic [7:0]                    r_rd_raw;
    logic [7:0]                    r_rd_fill;
    logic                          r_rd_hit;

    // An entry that was not written since reset or the last fill reads as the fill value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (i_req.fill_en) begin
            r_valid <= '0;
            r_fill  <= i_req.fill_byte;
        end else if (i_req.wr_en) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_raw <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_hit  <= r_valid[i_req.addr];
            r_rd_fill <= r_fill;
        end
    end

    assign o_rdata = r_rd_hit ? r_rd_raw : r_rd_fill;

endmodule

// ===== rtl/lmrs_ctrl.sv =====
// Sequencer that runs ticks, pixel accesses, fills and row refreshes on the shared adder.
module lmrs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lmrs_in_if.sink            i_in,
    lmrs_out_if.source         o_res,
    input  lmrs_pkg::t_cfg     i_cfg,
    output lmrs_pkg::t_alu_req o_alu_req,
    input  lmrs_pkg::t_alu_rsp i_alu_rsp,
    output lmrs_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_rdata
);

    lmrs_pkg::t_state r_state, n_state;
    lmrs_pkg::t_mode  r_mode, n_mode;
    logic [6:0]       r_col, n_col;
    logic [3:0]       r_row, n_row;
    logic             r_val, n_val;
    logic [7:0]       r_fill_byte, n_fill_byte;
    logic [lmrs_pkg::ALU_W-1:0]  r_elapsed, n_elapsed;
    logic [lmrs_pkg::ROW_W-1:0]  r_scan_row, n_scan_row;
    logic [lmrs_pkg::POS_W-1:0]  r_acc, n_acc;
    logic             r_err, n_err;
    logic [lmrs_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [lmrs_pkg::K_W-1:0]    r_k, n_k;

    logic             r_ov, n_ov;
    lmrs_pkg::t_kind  r_kind, n_kind;
    logic             r_pix, n_pix;
    logic [7:0]       r_sbyte, n_sbyte;
    logic [3:0]       r_arow, n_arow;
    logic             r_last, n_last;
    logic             r_err_o, n_err_o;

    logic             slot_free;
    logic             row_bad;
    logic             last_byte;
    logic [2:0]       bit_sel;
    logic [7:0]       mod_byte;
    logic [lmrs_pkg::ROW_W-1:0] new_row;

    assign slot_free = !r_ov || o_res.ready;
    assign row_bad   = {1'b0, r_row} >= 5'(lmrs_pkg::ROW_COUNT);
    assign last_byte = r_k == lmrs_pkg::K_W'(lmrs_pkg::BYTES_PER_ROW - 1);
    assign bit_sel   = 3'd7 - r_acc[2:0];

    always_comb begin
        mod_byte          = i_rdata;
        mod_byte[bit_sel] = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lmrs_pkg::ST_IDLE;
            r_elapsed  <= '0;
            r_scan_row <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_elapsed  <= n_elapsed;
            r_scan_row <= n_scan_row;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_col       <= n_col;
        r_row       <= n_row;
        r_val       <= n_val;
        r_fill_byte <= n_fill_byte;
        r_acc       <= n_acc;
        r_err       <= n_err;
        r_addr      <= n_addr;
        r_k         <= n_k;
        r_kind      <= n_kind;
        r_pix       <= n_pix;
        r_sbyte     <= n_sbyte;
        r_arow      <= n_arow;
        r_last      <= n_last;
        r_err_o     <= n_err_o;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_col       = r_col;
        n_row       = r_row;
        n_val       = r_val;
        n_fill_byte = r_fill_byte;
        n_elapsed   = r_elapsed;
        n_scan_row  = r_scan_row;
        n_acc       = r_acc;
        n_err       = r_err;
        n_addr      = r_addr;
        n_k         = r_k;
        n_ov        = r_ov && !o_res.ready;
        n_kind      = r_kind;
        n_pix       = r_pix;
        n_sbyte     = r_sbyte;
        n_arow      = r_arow;
        n_last      = r_last;
        n_err_o     = r_err_o;
        new_row     = '0;

        o_alu_req.op = lmrs_pkg::ALU_ADD;
        o_alu_req.a  = '0;
        o_alu_req.b  = '0;

        o_mem_req.rd_en     = 1'b0;
        o_mem_req.wr_en     = 1'b0;
        o_mem_req.fill_en   = 1'b0;
        o_mem_req.addr      = r_addr;
        o_mem_req.wdata     = mod_byte;
        o_mem_req.fill_byte = r_fill_byte;

        unique case (r_state)
            lmrs_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_mode      = lmrs_pkg::t_mode'(i_in.mode);
                    n_col       = i_in.column;
                    n_row       = i_in.row;
                    n_val       = i_in.pixel_value;
                    n_fill_byte = i_in.fill_byte;
                    unique case (lmrs_pkg::t_mode'(i_in.mode))
                        lmrs_pkg::MODE_TICK:  n_state = lmrs_pkg::ST_TICK_ADD;
                        lmrs_pkg::MODE_WRITE: n_state = lmrs_pkg::ST_PIX_POS;
                        lmrs_pkg::MODE_READ:  n_state = lmrs_pkg::ST_PIX_POS;
                        lmrs_pkg::MODE_FILL:  n_state = lmrs_pkg::ST_FILL;
                    endcase
                end
            end
            lmrs_pkg::ST_TICK_ADD: begin
                o_alu_req.a = r_elapsed;
                o_alu_req.b = lmrs_pkg::ALU_W'(1);
                n_elapsed   = i_alu_rsp.sum;
                n_state     = lmrs_pkg::ST_TICK_CMP;
            end
            lmrs_pkg::ST_TICK_CMP: begin
                o_alu_req.op = lmrs_pkg::ALU_GT;
                o_alu_req.a  = r_elapsed;
                o_alu_req.b  = lmrs_pkg::ALU_W'(i_cfg.row_period);
                if (i_alu_rsp.gt) begin
                    n_elapsed = '0;
                    n_state   = lmrs_pkg::ST_ROW_ADD;
                end else begin
                    n_state = lmrs_pkg::ST_IDLE;
                end
            end
            lmrs_pkg::ST_ROW_ADD: begin
                o_alu_req.a = lmrs_pkg::ALU_W'(r_scan_row);
                o_alu_req.b = lmrs_pkg::ALU_W'(1);
                n_acc       = i_alu_rsp.sum[lmrs_pkg::POS_W-1:0];
                n_state     = lmrs_pkg::ST_ROW_WRAP;
            end
            lmrs_pkg::ST_ROW_WRAP: begin
                o_alu_req.op = lmrs_pkg::ALU_GT;
                o_alu_req.a  = lmrs_pkg::ALU_W'(r_acc);
                o_alu_req.b  = lmrs_pkg::ALU_W'(lmrs_pkg::ROW_COUNT - 1);
                new_row      = i_alu_rsp.gt ? '0 : r_acc[lmrs_pkg::ROW_W-1:0];
                n_scan_row   = new_row;
                n_addr       = lmrs_pkg::ADDR_W'(int'(new_row) * lmrs_pkg::BYTES_PER_ROW);
                n_k          = '0;
                n_state      = lmrs_pkg::ST_SCAN_RD;
            end
            lmrs_pkg::ST_SCAN_RD: begin
                o_mem_req.rd_en = 1'b1;
                n_state         = lmrs_pkg::ST_SCAN_OUT;
            end
            lmrs_pkg::ST_SCAN_OUT: begin
                o_alu_req.a = lmrs_pkg::ALU_W'(r_addr);
                o_alu_req.b = lmrs_pkg::ALU_W'(1);
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_kind  = lmrs_pkg::KIND_SHIFT;
                    n_pix   = 1'b0;
                    n_sbyte = ~i_rdata;
                    n_arow  = 4'(r_scan_row);
                    n_last  = last_byte;
                    n_err_o = 1'b0;
                    if (last_byte) begin
                        n_state = lmrs_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k + lmrs_pkg::K_W'(1);
                        n_addr  = i_alu_rsp.sum[lmrs_pkg::ADDR_W-1:0];
                        n_state = lmrs_pkg::ST_SCAN_RD;
                    end
                end
            end
            lmrs_pkg::ST_PIX_POS: begin
                o_alu_req.a = lmrs_pkg::ALU_W'(r_col);
                o_alu_req.b = lmrs_pkg::ALU_W'(i_cfg.hidden_columns);
                n_acc       = i_alu_rsp.sum[lmrs_pkg::POS_W-1:0];
                n_state     = lmrs_pkg::ST_PIX_CHK;
            end
            lmrs_pkg::ST_PIX_CHK: begin
                o_alu_req.op = lmrs_pkg::ALU_GT;
                o_alu_req.a  = lmrs_pkg::ALU_W'(r_acc[lmrs_pkg::POS_W-1:3]);
                o_alu_req.b  = lmrs_pkg::ALU_W'(lmrs_pkg::BYTES_PER_ROW - 1);
                n_err        = i_alu_rsp.gt || row_bad;
                n_state      = (i_alu_rsp.gt || row_bad) ? lmrs_pkg::ST_PIX_RESULT
                                                         : lmrs_pkg::ST_PIX_ADDR;
            end
            lmrs_pkg::ST_PIX_ADDR: begin
                o_alu_req.a = lmrs_pkg::ALU_W'(int'(r_row) * lmrs_pkg::BYTES_PER_ROW);
                o_alu_req.b = lmrs_pkg::ALU_W'(r_acc[lmrs_pkg::POS_W-1:3]);
                n_addr      = i_alu_rsp.sum[lmrs_pkg::ADDR_W-1:0];
                n_state     = lmrs_pkg::ST_PIX_RD;
            end
            lmrs_pkg::ST_PIX_RD: begin
                o_mem_req.rd_en = 1'b1;
                n_state         = lmrs_pkg::ST_PIX_RESULT;
            end
            lmrs_pkg::ST_PIX_RESULT: begin
                if (slot_free) begin
                    o_mem_req.wr_en = (r_mode == lmrs_pkg::MODE_WRITE) && !r_err;
                    n_ov    = 1'b1;
                    n_kind  = (r_mode == lmrs_pkg::MODE_READ) ? lmrs_pkg::KIND_READ
                                                              : lmrs_pkg::KIND_ACK;
                    n_pix   = (r_mode == lmrs_pkg::MODE_READ) && !r_err && i_rdata[bit_sel];
                    n_sbyte = '0;
                    n_arow  = 4'(r_scan_row);
                    n_last  = 1'b1;
                    n_err_o = r_err;
                    n_state = lmrs_pkg::ST_IDLE;
                end
            end
            lmrs_pkg::ST_FILL: begin
                if (slot_free) begin
                    o_mem_req.fill_en = 1'b1;
                    n_ov    = 1'b1;
                    n_kind  = lmrs_pkg::KIND_ACK;
                    n_pix   = 1'b0;
                    n_sbyte = '0;
                    n_arow  = 4'(r_scan_row);
                    n_last  = 1'b1;
                    n_err_o = 1'b0;
                    n_state = lmrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmrs_pkg::ST_IDLE;
            end
        endcase
    end

    assign i_in.ready       = (r_state == lmrs_pkg::ST_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.kind       = r_kind;
    assign o_res.pixel_out  = r_pix;
    assign o_res.shift_byte = r_sbyte;
    assign o_res.active_row = r_arow;
    assign o_res.last       = r_last;
    assign o_res.error      = r_err_o;

    // A transaction is taken only when idle, so the sequencer always leaves idle next.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state != lmrs_pkg::ST_IDLE)
        else $error("sequencer stayed idle after taking a command");

    // The scan row never leaves the range of physical rows.
    a_scan_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_scan_row} < (lmrs_pkg::ROW_W + 1)'(lmrs_pkg::ROW_COUNT))
        else $error("scan row out of range");

    // Every store access stays inside the frame store.
    a_store_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en || o_mem_req.wr_en |->
        {1'b0, o_mem_req.addr} < (lmrs_pkg::ADDR_W + 1)'(lmrs_pkg::STORE_SIZE))
        else $error("frame store access out of range");

    // A row advance always restarts the tick count.
    a_advance_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lmrs_pkg::ST_TICK_CMP && i_alu_rsp.gt |=> r_elapsed == '0)
        else $error("tick count not cleared on row advance");

endmodule
